FILE: design/atp_pkg.sv
// Shared types and constants for the AT command line parser.
// No dependencies; imported by atp_front, atp_back and the top level.
`default_nettype none

package atp_pkg;

  localparam int LINE_MAX_DEF = 256;
  localparam int QUEUE_DEPTH  = 2;

  localparam logic [7:0] CH_A  = 8'h41;
  localparam logic [7:0] CH_T  = 8'h54;
  localparam logic [7:0] CH_EQ = 8'h3D;
  localparam logic [7:0] CH_Q  = 8'h3F;
  localparam logic [7:0] CH_LF = 8'd10;
  localparam logic [7:0] CH_CR = 8'd13;
  localparam logic [7:0] DELIM_RESET = 8'd44;

  localparam logic [1:0] CMD_EXEC  = 2'd0;
  localparam logic [1:0] CMD_READ  = 2'd1;
  localparam logic [1:0] CMD_WRITE = 2'd2;
  localparam logic [1:0] CMD_TEST  = 2'd3;

  localparam logic [1:0] EV_START = 2'd0;
  localparam logic [1:0] EV_BYTE  = 2'd1;
  localparam logic [1:0] EV_END   = 2'd2;

  // one classified byte, front to back
  typedef struct packed {
    logic [1:0] kind;
    logic       is_eq;
    logic       is_q;
    logic       is_delim;
  } ev_t;

  typedef struct packed {
    logic [7:0] line_length;
    logic [7:0] name_length;
    logic [1:0] command_type;
    logic [7:0] param_count;
    logic       param_error;
  } res_t;

endpackage

`default_nettype wire

FILE: design/atp_fifo.sv
// Small register queue, used between front and back and on the result side.
// Depends on nothing but its parameters.
`default_nettype none

module atp_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

FILE: design/atp_front.sv
// Front end: AT hunt, terminator and overlong-line detection, byte classification.
// Depends on atp_pkg; feeds classified bytes into the event queue.
`default_nettype none

module atp_front
  import atp_pkg::*;
#(
  parameter int LINE_MAX = LINE_MAX_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_write_en,
  input  wire logic [7:0] cfg_param_delimiter,
  input  wire logic       accept,
  input  wire logic [7:0] rx_byte,
  output logic            ev_push,
  output ev_t             ev
);

  localparam int CNT_W = $clog2(LINE_MAX);
  localparam logic [CNT_W-1:0] LINE_LIM = CNT_W'(LINE_MAX - 2);

  logic             collecting_r, collecting_nxt;
  logic [7:0]       prev_byte_r, prev_byte_nxt;
  logic [CNT_W-1:0] line_cnt_r, line_cnt_nxt;
  logic [7:0]       delim_r;
  logic             is_term;

  assign is_term = (rx_byte == CH_LF) || (rx_byte == CH_CR);

  always_comb begin
    collecting_nxt = collecting_r;
    prev_byte_nxt  = prev_byte_r;
    line_cnt_nxt   = line_cnt_r;
    ev_push        = 1'b0;
    ev.kind        = EV_BYTE;
    ev.is_eq       = (rx_byte == CH_EQ);
    ev.is_q        = (rx_byte == CH_Q);
    ev.is_delim    = (rx_byte == delim_r);
    if (accept) begin
      prev_byte_nxt = rx_byte;
      if (!collecting_r) begin
        if (prev_byte_r == CH_A && rx_byte == CH_T) begin
          collecting_nxt = 1'b1;
          line_cnt_nxt   = CNT_W'(2);
          ev_push        = 1'b1;
          ev.kind        = EV_START;
        end
      end else if (is_term) begin
        collecting_nxt = 1'b0;
        ev_push        = 1'b1;
        ev.kind        = EV_END;
      end else if (line_cnt_r >= LINE_LIM) begin
        // overlong: drop silently, back end is reset by the next START
        collecting_nxt = 1'b0;
      end else begin
        line_cnt_nxt = line_cnt_r + 1'b1;
        ev_push      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      collecting_r <= 1'b0;
      prev_byte_r  <= '0;
      line_cnt_r   <= '0;
      delim_r      <= DELIM_RESET;
    end else begin
      collecting_r <= collecting_nxt;
      prev_byte_r  <= prev_byte_nxt;
      line_cnt_r   <= line_cnt_nxt;
      if (cfg_write_en) begin
        delim_r <= cfg_param_delimiter;
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/atp_back.sv
// Back end: per-line counters and command typing, builds the line summary.
// Depends on atp_pkg; drains the event queue and fills the result queue.
`default_nettype none

module atp_back
  import atp_pkg::*;
#(
  parameter int LINE_MAX = LINE_MAX_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic ev_empty,
  input  ev_t       ev,
  output logic      ev_pop,
  input  wire logic res_full,
  output logic      res_push,
  output res_t      res
);

  localparam int CNT_W = $clog2(LINE_MAX);

  logic [CNT_W-1:0] line_cnt_r, line_cnt_nxt;
  logic [CNT_W-1:0] name_cnt_r, name_cnt_nxt;
  logic [CNT_W-1:0] delim_cnt_r, delim_cnt_nxt;
  logic             type_found_r, type_found_nxt;
  logic [1:0]       kind_r, kind_nxt;
  logic             after_eq_r, after_eq_nxt;
  logic             jae_r, jae_nxt;
  logic             is_end, err;
  logic [CNT_W+7:0] line_ext, name_ext, delim_ext;

  assign is_end   = (ev.kind == EV_END);
  assign ev_pop   = !ev_empty && (!is_end || !res_full);
  assign res_push = !ev_empty && is_end && !res_full;

  assign err       = after_eq_r && jae_r;
  assign line_ext  = {8'd0, line_cnt_r};
  assign name_ext  = {8'd0, name_cnt_r};
  assign delim_ext = {8'd0, delim_cnt_r} + 1'b1;

  assign res.line_length  = line_ext[7:0];
  assign res.name_length  = name_ext[7:0];
  assign res.command_type = kind_r;
  assign res.param_count  = (after_eq_r && !err) ? delim_ext[7:0] : 8'd0;
  assign res.param_error  = err;

  always_comb begin
    line_cnt_nxt   = line_cnt_r;
    name_cnt_nxt   = name_cnt_r;
    delim_cnt_nxt  = delim_cnt_r;
    type_found_nxt = type_found_r;
    kind_nxt       = kind_r;
    after_eq_nxt   = after_eq_r;
    jae_nxt        = jae_r;
    if (ev_pop) begin
      unique case (ev.kind)
        EV_START: begin
          line_cnt_nxt   = CNT_W'(2);
          name_cnt_nxt   = CNT_W'(2);
          delim_cnt_nxt  = '0;
          type_found_nxt = 1'b0;
          kind_nxt       = CMD_EXEC;
          after_eq_nxt   = 1'b0;
          jae_nxt        = 1'b0;
        end
        EV_BYTE: begin
          jae_nxt = 1'b0;
          // "=?" right after the type-deciding '=' makes it a test command
          if (jae_r && ev.is_q && kind_r == CMD_WRITE) begin
            kind_nxt = CMD_TEST;
          end
          if (!type_found_r) begin
            if (ev.is_eq) begin
              type_found_nxt = 1'b1;
              kind_nxt       = CMD_WRITE;
            end else if (ev.is_q) begin
              type_found_nxt = 1'b1;
              kind_nxt       = CMD_READ;
            end else begin
              name_cnt_nxt = name_cnt_r + 1'b1;
            end
          end
          if (!after_eq_r && ev.is_eq) begin
            after_eq_nxt = 1'b1;
            jae_nxt      = 1'b1;
          end
          // uses the updated flag: a '=' delimiter counts itself
          if (after_eq_nxt && ev.is_delim) begin
            delim_cnt_nxt = delim_cnt_r + 1'b1;
          end
          line_cnt_nxt = line_cnt_r + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_cnt_r   <= '0;
      name_cnt_r   <= '0;
      delim_cnt_r  <= '0;
      type_found_r <= 1'b0;
      kind_r       <= CMD_EXEC;
      after_eq_r   <= 1'b0;
      jae_r        <= 1'b0;
    end else begin
      line_cnt_r   <= line_cnt_nxt;
      name_cnt_r   <= name_cnt_nxt;
      delim_cnt_r  <= delim_cnt_nxt;
      type_found_r <= type_found_nxt;
      kind_r       <= kind_nxt;
      after_eq_r   <= after_eq_nxt;
      jae_r        <= jae_nxt;
    end
  end

  a_name_le_line: assert property (@(posedge clk) disable iff (!rst_n)
    name_cnt_r <= line_cnt_r)
    else $error("name count exceeds line count");

  a_exec_until_typed: assert property (@(posedge clk) disable iff (!rst_n)
    !type_found_r |-> kind_r == CMD_EXEC)
    else $error("command type set without a type byte");

  a_jae_implies_eq: assert property (@(posedge clk) disable iff (!rst_n)
    jae_r |-> after_eq_r)
    else $error("just-after-equals without equals");

  a_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (ev_pop && ev.kind == EV_START) |=> (line_cnt_r == CNT_W'(2) && delim_cnt_r == '0))
    else $error("line start did not reset counters");

endmodule

`default_nettype wire

FILE: design/at_command_line_parser.sv
// AT command line parser, top level: front end, event queue, back end, result queue.
// A result appears (empty low) once the CR/LF's END event has passed both queues.
// Throughput: one byte per cycle; full only rises when the result queue backs up
// through the 2-entry event queue.
// Reset: synchronous, active low; hunts for "AT", delimiter returns to ','.
// Depends on atp_pkg, atp_fifo, atp_front, atp_back.
`default_nettype none

module at_command_line_parser
  import atp_pkg::*;
#(
  parameter int LINE_MAX = LINE_MAX_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_write_en,
  input  wire logic [7:0] cfg_param_delimiter,
  input  wire logic       push,
  output logic            full,
  input  wire logic [7:0] in_rx_byte,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      out_line_length,
  output logic [7:0]      out_name_length,
  output logic [1:0]      out_command_type,
  output logic [7:0]      out_param_count,
  output logic            out_param_error
);

  logic                  accept;
  logic                  ev_push, ev_pop, ev_empty;
  ev_t                   ev_in;
  logic [$bits(ev_t)-1:0]  ev_q;
  logic                  res_push, res_full;
  res_t                  res_in, res_out;
  logic [$bits(res_t)-1:0] res_q;

  assign accept = push && !full;

  atp_front #(.LINE_MAX(LINE_MAX)) u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_write_en        (cfg_write_en),
    .cfg_param_delimiter (cfg_param_delimiter),
    .accept              (accept),
    .rx_byte             (in_rx_byte),
    .ev_push             (ev_push),
    .ev                  (ev_in)
  );

  atp_fifo #(.WIDTH($bits(ev_t)), .DEPTH(QUEUE_DEPTH)) u_evq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (ev_push),
    .wdata (ev_in),
    .full  (full),
    .pop   (ev_pop),
    .rdata (ev_q),
    .empty (ev_empty)
  );

  atp_back #(.LINE_MAX(LINE_MAX)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .ev_empty (ev_empty),
    .ev       (ev_t'(ev_q)),
    .ev_pop   (ev_pop),
    .res_full (res_full),
    .res_push (res_push),
    .res      (res_in)
  );

  atp_fifo #(.WIDTH($bits(res_t)), .DEPTH(QUEUE_DEPTH)) u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_q),
    .empty (empty)
  );

  assign res_out          = res_t'(res_q);
  assign out_line_length  = res_out.line_length;
  assign out_name_length  = res_out.name_length;
  assign out_command_type = res_out.command_type;
  assign out_param_count  = res_out.param_count;
  assign out_param_error  = res_out.param_error;

endmodule

`default_nettype wire
